### src/sliding_window_median_defines.svh
// Assertion macros shared by the sliding window median RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding window median: same-cycle check failed");

// next-cycle implication
`define SWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window median: next-cycle check failed");

`endif

### src/swm_pkg.sv
// Package for the sliding window median filter: sizes, cell types and
// the window length clamp. No dependencies.
package swm_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int OUT_W        = SAMPLE_WIDTH + 1;
  localparam int CFG_W        = 5;
  localparam int IDX_W        = $clog2(MAX_WINDOW);
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W        = IDX_W;
  localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic             valid;
    logic [AGE_W-1:0] age;
    sample_t          value;
  } cell_ent_t;

  typedef struct packed {
    cell_ent_t ent;
    logic      gt;
  } cell_link_t;

  typedef struct packed {
    logic             step;
    logic             clean;
    logic             first;
    sample_t          sample;
    logic [CNT_W-1:0] win;
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] w;
    if (cfg == '0) begin
      w = CNT_W'(1);
    end else if (int'(cfg) > MAX_WINDOW) begin
      w = CNT_W'(MAX_WINDOW);
    end else begin
      w = CNT_W'(cfg);
    end
    return w;
  endfunction

endpackage

### src/swm_cell.sv
// One slot of the sorted window: value, age and valid bit.
// Drops, compacts and inserts using its neighbors only. Uses swm_pkg.
module swm_cell import swm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left_link,
  input  cell_ent_t  right_ent,
  input  logic       del_in,
  output cell_ent_t  ent_q,
  output cell_ent_t  ent_nxt,
  output cell_link_t link_out,
  output logic       del_out
);

  logic             valid_r;
  logic [AGE_W-1:0] age_r;
  sample_t          value_r;
  logic [CNT_W-1:0] age_x;
  logic [CNT_W-1:0] age_inc;
  logic             del_here;
  logic             shift;
  logic             take_left;
  logic             take_new;
  cell_ent_t        cmp_ent;

  assign ent_q = '{valid: valid_r, age: age_r, value: value_r};

  always_comb begin
    age_x    = CNT_W'(age_r);
    age_inc  = age_x + CNT_W'(1);
    del_here = valid_r & (ctrl.clean ? (age_x >= ctrl.win) : (age_inc >= ctrl.win));
    shift    = del_in | del_here;
    cmp_ent  = shift ? right_ent : ent_q;
    if (ctrl.first) begin
      cmp_ent.valid = 1'b0;
    end
    if (ctrl.step) begin
      cmp_ent.age = cmp_ent.age + AGE_W'(1);
    end
    link_out.ent = cmp_ent;
    link_out.gt  = cmp_ent.valid & ($signed(cmp_ent.value) > $signed(ctrl.sample));
    take_left = left_link.ent.valid & left_link.gt;
    take_new  = ~take_left & left_link.ent.valid & (link_out.gt | ~cmp_ent.valid);
    ent_nxt = cmp_ent;
    if (ctrl.step) begin
      if (take_left) begin
        ent_nxt = left_link.ent;
      end else if (take_new) begin
        ent_nxt = '{valid: 1'b1, age: '0, value: ctrl.sample};
      end
    end
    del_out = shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.step | ctrl.clean) begin
      valid_r <= ent_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step | ctrl.clean) begin
      age_r   <= ent_nxt.age;
      value_r <= ent_nxt.value;
    end
  end

endmodule

### src/sliding_window_median.sv
// A transfer updates the cells and pend_r; median_r then registers out_median_x2.
// Throughput: one sample per cycle unless in_stall; cells update on step or clean.
// A shortening window_size write stalls input until no stale entry remains.
// An output stall backs up into in_stall only while a second result is waiting.
// Reset (rst_n, synchronous): window empty, no result pending, window_size 3.
`include "sliding_window_median_defines.svh"
module sliding_window_median import swm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_first,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_median_x2,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_window_size
);

  logic [CFG_W-1:0]        win_cfg_r;
  logic [CNT_W-1:0]        win;
  cell_ctrl_t              ctrl;
  cell_ent_t               ent_q   [MAX_WINDOW+1];
  cell_ent_t               ent_nxt [MAX_WINDOW];
  cell_link_t              link    [MAX_WINDOW+1];
  logic [MAX_WINDOW:0]     del_chain;
  logic [MAX_WINDOW:0]     valid_vec;
  logic [MAX_WINDOW:0]     valid_nxt_vec;
  logic                    dirty;
  logic                    step;
  logic                    emit;
  logic                    pend_r;
  logic                    pend_nxt;
  logic                    ld;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] median_r;
  logic signed [OUT_W-1:0] median_nxt;
  logic [IDX_W-1:0]        lo_idx;
  logic [IDX_W-1:0]        hi_idx;
  logic [CNT_W-1:0]        win_m1;

  assign cfg_ready = 1'b1;
  assign win       = eff_window(win_cfg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_cfg_r <= cfg_window_size;
    end
  end

  always_comb begin
    dirty         = 1'b0;
    valid_vec     = '0;
    valid_nxt_vec = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      dirty            = dirty | (ent_q[j].valid & (CNT_W'(ent_q[j].age) >= win));
      valid_vec[j]     = ent_q[j].valid;
      valid_nxt_vec[j] = ent_nxt[j].valid;
    end
  end

  assign in_stall = dirty | (pend_r & out_valid_r & out_stall);
  assign step     = in_valid & ~in_stall;

  always_comb begin
    ctrl.step   = step;
    ctrl.clean  = dirty;
    ctrl.first  = step & in_first;
    ctrl.sample = in_sample;
    ctrl.win    = win;
  end

  assign ent_q[MAX_WINDOW] = '0;
  assign link[0]           = '{ent: '{valid: 1'b1, age: '0, value: '0}, gt: 1'b0};
  assign del_chain[0]      = 1'b0;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    swm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_link(link[j]),
      .right_ent(ent_q[j+1]),
      .del_in   (del_chain[j]),
      .ent_q    (ent_q[j]),
      .ent_nxt  (ent_nxt[j]),
      .link_out (link[j+1]),
      .del_out  (del_chain[j+1])
    );
  end

  // the window holds exactly win entries after this transfer
  assign win_m1 = win - CNT_W'(1);
  assign emit   = valid_nxt_vec[win_m1] & ~valid_nxt_vec[win];

  assign ld            = pend_r & (~out_valid_r | ~out_stall);
  assign pend_nxt      = (step & emit) | (pend_r & ~ld);
  assign out_valid_nxt = ld | (out_valid_r & out_stall);

  assign lo_idx     = IDX_W'(win_m1 >> 1);
  assign hi_idx     = IDX_W'(win >> 1);
  assign median_nxt = OUT_W'($signed(ent_q[lo_idx].value)) + OUT_W'($signed(ent_q[hi_idx].value));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      median_r <= median_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_median_x2 = median_r;

  `SWM_ASSERT_IMP(a_valid_prefix, 1'b1, (valid_vec & (valid_vec + (MAX_WINDOW+1)'(1))) == '0)
  `SWM_ASSERT_IMP(a_fill_bound, !dirty, $countones(valid_vec) <= int'(win))
  `SWM_ASSERT_IMP(a_clean_drops, dirty, del_chain[MAX_WINDOW])
  `SWM_ASSERT_IMP(a_no_overflow, step, !link[MAX_WINDOW].ent.valid)
  `SWM_ASSERT_NXT(a_pend_held, pend_r && out_valid_r && out_stall, pend_r)

endmodule
